[design/sat_pkg.sv]
// shared types and constants for the section address translator
package sat_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_V2F   = 2'd2,
    OP_F2V   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_FILE_ALIGN = 1'b0,
    CFG_SECT_ALIGN = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_CMP,
    ST_DONE
  } state_t;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned DIV_STEPS  = ADDR_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  localparam logic [ADDR_W-1:0] FILE_ALIGN_RST = 32'd512;
  localparam logic [ADDR_W-1:0] SECT_ALIGN_RST = 32'd4096;
  localparam logic [ADDR_W-1:0] ALL_ONES       = '1;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] raw_start;
    logic [ADDR_W-1:0] raw_size;
    logic [ADDR_W-1:0] virt_start;
    logic [ADDR_W-1:0] virt_size;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  translated;
    logic [ADDR_W-1:0]  raw_end_rounded;
    logic [ADDR_W-1:0]  virt_end_rounded;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] raw_begin;
    logic [ADDR_W-1:0] raw_end;
    logic [ADDR_W-1:0] virt_begin;
    logic [ADDR_W-1:0] virt_end;
  } region_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_step;
    logic rd_issue;
    logic cmp;
    logic idx_inc;
    logic finish;
  } sat_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  new_op;
    op_t  op;
    logic div_last;
    logic cnt_zero;
    logic hit;
    logic idx_last;
  } sat_stat_t;

endpackage

[design/sat_ctrl.sv]
// controller state machine for the section address translator
module sat_ctrl import sat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  sat_stat_t st,
  output sat_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (st.new_op)
            OP_CLEAR: state_nxt = ST_DONE;
            OP_LOAD:  state_nxt = ST_DIV;
            OP_V2F,
            OP_F2V:   state_nxt = st.cnt_zero ? ST_DONE : ST_RD;
          endcase
        end
      end
      ST_DIV: begin
        if (st.div_last) state_nxt = ST_DONE;
      end
      ST_RD:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (st.hit || st.idx_last) state_nxt = ST_DONE;
        else state_nxt = ST_RD;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DIV: cmd.div_step = 1'b1;
      ST_RD:  cmd.rd_issue = 1'b1;
      ST_CMP: begin
        cmd.cmp     = 1'b1;
        cmd.idx_inc = !st.hit && !st.idx_last;
      end
      ST_DONE: cmd.finish = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result overwritten while still pending");

  a_scan_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (st.op == OP_V2F || st.op == OP_F2V))
    else $error("table scan on a non-query transaction");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted transaction dropped");

endmodule

[design/sat_dp.sv]
// datapath: config registers, region memory, remainder units, scan compare
module sat_dp import sat_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  in_item_t          in_data,
  input  sat_cmd_t          cmd,
  output sat_stat_t         st,
  output out_item_t         out_data
);

  localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

  logic [ADDR_W-1:0] file_align_r, sect_align_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [STEP_W-1:0] step_r;
  logic              hit_r;
  in_item_t          item_r;
  logic [ADDR_W-1:0] trans_r;
  out_item_t         out_r, out_nxt;
  region_t           rd_data_r, wr_entry;
  region_t           mem [MAX_SECTIONS];

  logic [1:0][ADDR_W-1:0] align, end_r, dvd_r, rem_r, rem_step, rounded;
  logic [1:0][ADDR_W:0]   shift_val;
  logic [ADDR_W-1:0]      lo, hi, other;
  logic                   hit, full, wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_align_r <= FILE_ALIGN_RST;
      sect_align_r <= SECT_ALIGN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FILE_ALIGN: file_align_r <= cfg_data;
        CFG_SECT_ALIGN: sect_align_r <= cfg_data;
      endcase
    end
  end

  assign align[0] = file_align_r;
  assign align[1] = sect_align_r;

  // one restoring remainder step per lane
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      shift_val[k] = {rem_r[k], dvd_r[k][ADDR_W-1]};
      if (shift_val[k] >= {1'b0, align[k]}) begin
        rem_step[k] = ADDR_W'(shift_val[k] - {1'b0, align[k]});
      end else begin
        rem_step[k] = shift_val[k][ADDR_W-1:0];
      end
      if (align[k] == '0 || rem_r[k] == '0) begin
        rounded[k] = end_r[k];
      end else begin
        rounded[k] = end_r[k] - rem_r[k] + align[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r   <= in_data;
      end_r[0] <= in_data.raw_start + in_data.raw_size;
      end_r[1] <= in_data.virt_start + in_data.virt_size;
      dvd_r[0] <= in_data.raw_start + in_data.raw_size;
      dvd_r[1] <= in_data.virt_start + in_data.virt_size;
      rem_r    <= '0;
      step_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= rem_step;
      dvd_r[0] <= dvd_r[0] << 1;
      dvd_r[1] <= dvd_r[1] << 1;
      step_r   <= step_r + 1'b1;
    end
    if (cmd.cmp && hit) begin
      trans_r <= other + item_r.address - lo;
    end
  end

  // scan side
  always_comb begin
    if (item_r.op == OP_V2F) begin
      lo    = rd_data_r.virt_begin;
      hi    = rd_data_r.virt_end;
      other = rd_data_r.raw_begin;
    end else begin
      lo    = rd_data_r.raw_begin;
      hi    = rd_data_r.raw_end;
      other = rd_data_r.virt_begin;
    end
  end

  assign hit = (item_r.address >= lo) && (item_r.address <= hi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      if (cmd.capture) begin
        hit_r <= 1'b0;
        idx_r <= '0;
      end else begin
        if (cmd.cmp && hit) hit_r <= 1'b1;
        if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      end
      if (cmd.finish) count_r <= count_nxt;
    end
  end

  // region memory
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[IDX_W-1:0]] <= wr_entry;
  end

  assign full  = (count_r >= CNT_W'(MAX_SECTIONS));
  assign wr_en = cmd.finish && (item_r.op == OP_LOAD) && !full;

  always_comb begin
    wr_entry.raw_begin  = item_r.raw_start;
    wr_entry.raw_end    = end_r[0];
    wr_entry.virt_begin = item_r.virt_start;
    wr_entry.virt_end   = end_r[1];
  end

  always_comb begin
    count_nxt = count_r;
    if (item_r.op == OP_CLEAR) count_nxt = '0;
    else if (wr_en) count_nxt = count_r + 1'b1;
  end

  // result assembly
  always_comb begin
    out_nxt             = '0;
    out_nxt.status      = STATUS_OK;
    out_nxt.entry_count = COUNT_W'(count_nxt);
    unique case (item_r.op)
      OP_CLEAR: out_nxt.status = STATUS_OK;
      OP_LOAD: begin
        out_nxt.status           = full ? STATUS_FULL : STATUS_OK;
        out_nxt.raw_end_rounded  = rounded[0];
        out_nxt.virt_end_rounded = rounded[1];
      end
      OP_V2F,
      OP_F2V: begin
        out_nxt.status     = hit_r ? STATUS_OK : STATUS_MISS;
        out_nxt.translated = hit_r ? trans_r : ALL_ONES;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= out_nxt;
  end

  assign out_data = out_r;

  always_comb begin
    st          = '0;
    st.new_op   = in_data.op;
    st.op       = item_r.op;
    st.div_last = (step_r == STEP_W'(DIV_STEPS - 1));
    st.cnt_zero = (count_r == '0);
    st.hit      = hit;
    st.idx_last = ((CNT_W'(idx_r) + 1'b1) == count_r);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SECTIONS))
    else $error("region count beyond table depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (CNT_W'(idx_r) < count_r))
    else $error("scan reads an unwritten region");

endmodule

[design/section_address_translator.sv]
// top level of the section address translator
// The block holds up to MAX_SECTIONS section regions (file begin/end and
// virtual begin/end, ends wrapping modulo 2^32) in a single-port-read memory
// and handles one transaction at a time. A clear goes from accept straight
// to its result; a load captures its operands, runs a bit-serial remainder
// unit for both alignments side by side, one step per dividend bit, then
// commits; and a query captures, then visits held regions in order up to
// and including the first hit, or all held regions on a miss (each visit is
// one registered memory read plus one compare). The result sits in an output
// register, so the next transaction is taken while it waits; the block stalls
// only when a new result is ready and the previous one is still pending.
// Configuration writes are registered and should be issued only while idle.
module section_address_translator import sat_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  // input transactions
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // result transactions
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  sat_cmd_t  cmd;
  sat_stat_t st;

  // sequencing: idle, remainder loop, scan read / compare, result hand-off
  sat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // storage and arithmetic
  sat_dp #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

[sim/section_address_translator_tb.sv]
// self-checking testbench for the section address translator
`timescale 1ns / 1ps

module section_address_translator_tb;
  import sat_pkg::*;

  localparam int unsigned SECTIONS     = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned IDLE_PAUSE   = 40;   // longer than the slowest transaction
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES  = 300;  // receiver back-pressure stretch

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = CFG_FILE_ALIGN;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;

  // no random idling on either side while set
  bit          steady = 1'b0;
  // one-shot request for a long receiver hold-off
  bit          hold_request = 1'b0;
  int unsigned items_sent = 0;

  section_address_translator #(
    .MAX_SECTIONS(SECTIONS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // mirror of the region table plus the queue of results still owed by the block
  class translation_scoreboard;
    logic [ADDR_W-1:0] file_align;
    logic [ADDR_W-1:0] sect_align;
    logic [ADDR_W-1:0] raw_lo[SECTIONS];
    logic [ADDR_W-1:0] raw_hi[SECTIONS];
    logic [ADDR_W-1:0] virt_lo[SECTIONS];
    logic [ADDR_W-1:0] virt_hi[SECTIONS];
    int unsigned       held;
    out_item_t         pending_results[$];
    int unsigned       errors;

    function new();
      file_align = FILE_ALIGN_RST;
      sect_align = SECT_ALIGN_RST;
      held       = 0;
      errors     = 0;
    endfunction

    // round an end up to the granule; zero granule leaves it, result wraps mod 2^32
    function logic [ADDR_W-1:0] round_end(logic [ADDR_W-1:0] end_addr,
                                          logic [ADDR_W-1:0] gran);
      if (gran == 0 || end_addr % gran == 0) return end_addr;
      return (end_addr / gran + 1) * gran;
    endfunction

    // first held region whose inclusive range covers addr wins
    function logic [ADDR_W-1:0] map_address(logic [ADDR_W-1:0] addr, bit from_virt,
                                            output bit hit);
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [ADDR_W-1:0] other;
      hit = 1'b0;
      for (int i = 0; i < held; i++) begin
        lo    = from_virt ? virt_lo[i] : raw_lo[i];
        hi    = from_virt ? virt_hi[i] : raw_hi[i];
        other = from_virt ? raw_lo[i] : virt_lo[i];
        if (addr >= lo && addr <= hi) begin
          hit = 1'b1;
          return other + (addr - lo);
        end
      end
      return ALL_ONES;
    endfunction

    function out_item_t translate_item(in_item_t t);
      out_item_t r;
      bit        hit;
      r = '0;
      case (t.op)
        OP_CLEAR: held = 0;
        OP_LOAD: begin
          r.raw_end_rounded  = round_end(t.raw_start + t.raw_size, file_align);
          r.virt_end_rounded = round_end(t.virt_start + t.virt_size, sect_align);
          if (held >= SECTIONS) begin
            r.status = STATUS_FULL;
          end else begin
            raw_lo[held]  = t.raw_start;
            raw_hi[held]  = t.raw_start + t.raw_size;
            virt_lo[held] = t.virt_start;
            virt_hi[held] = t.virt_start + t.virt_size;
            held++;
          end
        end
        default: begin
          r.translated = map_address(t.address, t.op == OP_V2F, hit);
          r.status     = hit ? STATUS_OK : STATUS_MISS;
        end
      endcase
      r.entry_count = COUNT_W'(held);
      return r;
    endfunction

    function void note_input(in_item_t t);
      pending_results.insert(pending_results.size(), translate_item(t));
    endfunction

    function void compare_field(string field, logic [ADDR_W-1:0] want,
                                logic [ADDR_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: 0x%0h", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("translated", want.translated, got.translated);
      compare_field("raw_end_rounded", want.raw_end_rounded, got.raw_end_rounded);
      compare_field("virt_end_rounded", want.virt_end_rounded, got.virt_end_rounded);
      compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  translation_scoreboard scoreboard = new();

  // 10 ns clock
  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // result side: sample the handshake as it stood before the edge, then pick
  // the next ready level; a hold request forces a long stall so the block backs up
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) scoreboard.check_result(out_data);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || $urandom_range(99) >= 30;
      end
    end
  end

  function automatic in_item_t make_item(op_t op, logic [ADDR_W-1:0] addr,
                                         logic [ADDR_W-1:0] rs, logic [ADDR_W-1:0] rz,
                                         logic [ADDR_W-1:0] vs, logic [ADDR_W-1:0] vz);
    in_item_t t;
    t.op         = op;
    t.address    = addr;
    t.raw_start  = rs;
    t.raw_size   = rz;
    t.virt_start = vs;
    t.virt_size  = vz;
    return t;
  endfunction

  // offer one transaction, with random idle cycles ahead of it; valid stays
  // up on return so back-to-back transactions need no dip
  task automatic send_item(in_item_t item);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    scoreboard.note_input(item);
    items_sent++;
  endtask

  // region begins: anywhere, low and crowded (overlaps), near the top (wraps), page aligned
  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(16'hFFFF);
      2:       return ALL_ONES - $urandom_range(16'hFFFF);
      default: return $urandom_range(255) << 12;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_size();
    case ($urandom_range(4))
      0:       return '0;
      1:       return $urandom_range(16'h1FFF);
      2:       return $urandom;
      3:       return ALL_ONES - $urandom_range(3);
      default: return $urandom_range(32'h000F_FFFF);
    endcase
  endfunction

  // query address aimed at a held region: its edges, just outside them, or inside
  function automatic logic [ADDR_W-1:0] pick_address(bit virt_side);
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] span;
    int unsigned       idx;
    if (scoreboard.held == 0 || $urandom_range(9) == 0) return $urandom;
    idx  = $urandom_range(scoreboard.held - 1);
    lo   = virt_side ? scoreboard.virt_lo[idx] : scoreboard.raw_lo[idx];
    hi   = virt_side ? scoreboard.virt_hi[idx] : scoreboard.raw_hi[idx];
    span = hi - lo;
    case ($urandom_range(4))
      0:       return lo;
      1:       return hi;
      2:       return lo - 1;
      3:       return hi + 1;
      default: return (hi < lo || span == ALL_ONES) ? $urandom : lo + ($urandom % (span + 1));
    endcase
  endfunction

  // mostly clear, a run of loads (sometimes past full), then aimed queries;
  // now and then a burst of fully random transactions instead
  task automatic run_table_sequence();
    int unsigned loads;
    int unsigned queries;
    bit          virt_side;
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(1, 6))
        send_item(make_item(op_t'($urandom_range(3)), $urandom, $urandom, $urandom,
                            $urandom, $urandom));
      return;
    end
    loads   = ($urandom_range(4) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
    queries = $urandom_range(4, 14);
    if ($urandom_range(4) != 0)
      send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
    repeat (loads)
      send_item(make_item(OP_LOAD, $urandom, pick_base(), pick_size(), pick_base(),
                          pick_size()));
    repeat (queries) begin
      virt_side = $urandom_range(1);
      send_item(make_item(virt_side ? OP_V2F : OP_F2V, pick_address(virt_side),
                          $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  task automatic random_items(int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) run_table_sequence();
  endtask

  // alignment registers only change once the block has gone quiet
  task automatic set_alignments(logic [ADDR_W-1:0] file_gran, logic [ADDR_W-1:0] sect_gran);
    in_valid <= 1'b0;
    while (scoreboard.pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILE_ALIGN;
    cfg_data  <= file_gran;
    scoreboard.file_align = file_gran;
    @(posedge clk);
    cfg_index <= CFG_SECT_ALIGN;
    cfg_data  <= sect_gran;
    scoreboard.sect_align = sect_gran;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset alignments (512 / 4096)
    // empty table misses in both directions
    send_item(make_item(OP_V2F, '0, '0, '0, '0, '0));
    send_item(make_item(OP_F2V, ALL_ONES, '0, '0, '0, '0));
    // exact file end, virtual end rounded up
    send_item(make_item(OP_LOAD, '0, 32'h400, 32'h200, 32'h1000, 32'h180));
    // zero sizes: single-address region at zero
    send_item(make_item(OP_LOAD, '0, '0, '0, '0, '0));
    // file side wraps past 2^32, virtual end at the top rounds around to zero
    send_item(make_item(OP_LOAD, '0, 32'hFFFF_FF00, 32'h200, 32'hFFFF_F800, 32'h7FF));
    // top address, zero size
    send_item(make_item(OP_LOAD, '0, ALL_ONES, '0, ALL_ONES, '0));
    // overlaps the first region on the file side
    send_item(make_item(OP_LOAD, '0, 32'h500, 32'h1000, 32'h1100, 32'h100));
    // inclusive edges, first-hit priority, wrapped region skipped, hit arithmetic wrap
    send_item(make_item(OP_V2F, 32'h1000, '0, '0, '0, '0));
    send_item(make_item(OP_V2F, 32'h1180, '0, '0, '0, '0));
    send_item(make_item(OP_V2F, 32'h1181, '0, '0, '0, '0));
    send_item(make_item(OP_F2V, 32'h500, '0, '0, '0, '0));
    send_item(make_item(OP_F2V, '0, '0, '0, '0, '0));
    send_item(make_item(OP_F2V, 32'hFFFF_FF80, '0, '0, '0, '0));
    send_item(make_item(OP_V2F, ALL_ONES, '0, '0, '0, '0));
    send_item(make_item(OP_F2V, ALL_ONES, '0, '0, '0, '0));
    send_item(make_item(OP_F2V, 32'h601, '0, '0, '0, '0));
    send_item(make_item(OP_V2F, 32'h2000, '0, '0, '0, '0));
    // clear then miss
    send_item(make_item(OP_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    send_item(make_item(OP_V2F, 32'h1000, '0, '0, '0, '0));
    // all-ones fields: both ends wrap to just below the begin
    send_item(make_item(OP_LOAD, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    send_item(make_item(OP_F2V, ALL_ONES, '0, '0, '0, '0));

    random_items(130);

    // zero granules leave ends unrounded
    set_alignments('0, '0);
    random_items(125);

    // granule of one, with both sides running flat out
    set_alignments(32'd1, 32'd1);
    steady = 1'b1;
    random_items(125);
    steady = 1'b0;

    // largest granules; receiver stalls long enough to back the block up
    set_alignments(ALL_ONES, 32'h8000_0000);
    hold_request = 1'b1;
    random_items(125);

    // odd, non power-of-two granules
    set_alignments(32'd3, $urandom_range(5000, 1) | 32'd1);
    random_items(125);

    set_alignments($urandom, $urandom);
    random_items(120);

    in_valid <= 1'b0;
    while (scoreboard.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (scoreboard.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", scoreboard.pending_results.size());
      scoreboard.errors++;
    end
    if (scoreboard.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[section_address_translator.f]
design/sat_pkg.sv
design/sat_ctrl.sv
design/sat_dp.sv
design/section_address_translator.sv
sim/section_address_translator_tb.sv
